@@ hw/rtl/hbdcrc_pkg.sv @@
package hbdcrc_pkg;

  localparam int NODE_COUNT_DEF  = 512;
  localparam int LENGTH_BITS_DEF = 16;

  localparam int IDX_W = 9;
  localparam int SYM_W = 8;

  localparam logic [31:0] CRC_POLY = 32'hEDB8_8320;
  localparam logic [31:0] CRC_INIT = 32'hFFFF_FFFF;

  // Bit position of the first bit walked in a data byte.
  localparam logic [2:0] MSB_POS = 3'd7;

  localparam logic [1:0] MODE_LOAD = 2'd0;
  localparam logic [1:0] MODE_HDR  = 2'd1;
  localparam logic [1:0] MODE_DATA = 2'd2;

  localparam logic KIND_SYM  = 1'b0;
  localparam logic KIND_VERD = 1'b1;

  typedef struct packed {
    logic             leaf;
    logic [SYM_W-1:0] symbol;
    logic [IDX_W-1:0] left;
    logic [IDX_W-1:0] right;
  } node_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
    node_t            entry;
  } node_wr_t;

  typedef struct packed {
    logic             en;
    logic [IDX_W-1:0] idx;
  } node_rd_t;

  typedef struct packed {
    logic             kind;
    logic [SYM_W-1:0] symbol;
    logic             crc_ok;
  } res_t;

  // Fold one byte into a reflected CRC-32.
  function automatic logic [31:0] crc32_byte(input logic [31:0] crc,
                                             input logic [SYM_W-1:0] b);
    logic [31:0] c;
    c = crc ^ {24'b0, b};
    for (int i = 0; i < 8; i++) begin
      c = (c >> 1) ^ (CRC_POLY & {32{c[0]}});
    end
    return c;
  endfunction

endpackage

@@ hw/rtl/huffman_block_decoder_crc32_top.sv @@
// Channel | Direction | Handshake            | Payload
// in      | input     | in_valid / in_ready  | mode, node fields, header fields, data byte
// out     | output    | out_valid / out_ready| kind, symbol, crc_ok, last
//
// Loads, headers and data bytes with no open block are taken in S_IDLE; an empty header
// also passes S_FLUSH to flush its verdict. A data byte keeps in_ready low for S_RDCUR,
// then per bit S_BIT and S_CHILD when the bit starts from a fetched entry (the first bit
// and each bit after a symbol; S_BIT alone if the root is a leaf) or else S_CHILD alone,
// then S_FLUSH. A block end passes S_VERD and drops the rest of the byte. Reset (rst_n,
// synchronous) closes any block and empties the output stage; a stall holds the walk.
module huffman_block_decoder_crc32_top #(
  parameter int NODE_COUNT  = hbdcrc_pkg::NODE_COUNT_DEF,
  parameter int LENGTH_BITS = hbdcrc_pkg::LENGTH_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,

  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [8:0]  in_node_index,
  input  logic        in_node_is_leaf,
  input  logic [7:0]  in_node_symbol,
  input  logic [8:0]  in_node_left,
  input  logic [8:0]  in_node_right,
  input  logic [31:0] in_expected_crc,
  input  logic [15:0] in_block_length,
  input  logic [7:0]  in_data_byte,

  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_kind,
  output logic [7:0]  out_symbol,
  output logic        out_crc_ok,
  output logic        out_last
);
  import hbdcrc_pkg::*;

  typedef enum logic [5:0] {
    S_IDLE  = 6'b000001,
    S_RDCUR = 6'b000010,
    S_BIT   = 6'b000100,
    S_CHILD = 6'b001000,
    S_VERD  = 6'b010000,
    S_FLUSH = 6'b100000
  } state_t;

  state_t                 state_r, state_nxt;
  logic [2:0]             cnt_r, cnt_nxt;
  logic [SYM_W-1:0]       byte_r, byte_nxt;
  logic [IDX_W-1:0]       cur_idx_r, cur_idx_nxt;
  node_t                  cur_ent_r, cur_ent_nxt;
  logic [IDX_W-1:0]       child_r, child_nxt;
  node_t                  root_r, root_nxt;
  logic [31:0]            crc_r, crc_nxt;
  logic [31:0]            exp_r, exp_nxt;
  logic [LENGTH_BITS-1:0] rem_r, rem_nxt;
  logic                   active_r, active_nxt;
  logic                   pend_valid_r, pend_valid_nxt;
  res_t                   pend_r, pend_nxt;
  logic                   out_valid_r, out_valid_nxt;
  res_t                   out_r, out_nxt;
  logic                   out_last_r, out_last_nxt;

  node_wr_t               tbl_wr;
  node_rd_t               tbl_rd;
  node_t                  rd_ent;

  logic                   out_free;
  logic                   emit_req;
  logic [SYM_W-1:0]       emit_sym;
  logic                   cur_bit;
  logic                   next_bit;
  logic [IDX_W-1:0]       child;
  logic [LENGTH_BITS-1:0] hdr_len;

  hbdcrc_node_tbl #(
    .NODE_COUNT(NODE_COUNT)
  ) u_tbl (
    .clk   (clk),
    .wr    (tbl_wr),
    .rd    (tbl_rd),
    .rd_ent(rd_ent)
  );

  assign in_ready   = (state_r == S_IDLE);
  assign out_valid  = out_valid_r;
  assign out_kind   = out_r.kind;
  assign out_symbol = out_r.symbol;
  assign out_crc_ok = out_r.crc_ok;
  assign out_last   = out_last_r;

  assign out_free = !out_valid_r || out_ready;
  assign cur_bit  = byte_r[MSB_POS - cnt_r];
  assign next_bit = byte_r[MSB_POS - (cnt_r + 3'd1)];
  assign hdr_len  = LENGTH_BITS'(in_block_length);

  always_comb begin
    state_nxt      = state_r;
    cnt_nxt        = cnt_r;
    byte_nxt       = byte_r;
    cur_idx_nxt    = cur_idx_r;
    cur_ent_nxt    = cur_ent_r;
    child_nxt      = child_r;
    root_nxt       = root_r;
    crc_nxt        = crc_r;
    exp_nxt        = exp_r;
    rem_nxt        = rem_r;
    active_nxt     = active_r;
    pend_valid_nxt = pend_valid_r;
    pend_nxt       = pend_r;
    out_valid_nxt  = out_valid_r;
    out_nxt        = out_r;
    out_last_nxt   = out_last_r;
    tbl_wr         = '0;
    tbl_rd         = '0;
    emit_req       = 1'b0;
    emit_sym       = '0;
    child          = '0;

    // Drop the output beat once the consumer takes it.
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          unique case (in_mode)
            MODE_LOAD: begin
              tbl_wr.en           = 1'b1;
              tbl_wr.idx          = in_node_index;
              tbl_wr.entry.leaf   = in_node_is_leaf;
              tbl_wr.entry.symbol = in_node_symbol;
              tbl_wr.entry.left   = in_node_left;
              tbl_wr.entry.right  = in_node_right;
              // Keep a copy of the root for the return after each leaf.
              if (in_node_index == '0) begin
                root_nxt = tbl_wr.entry;
              end
            end
            MODE_HDR: begin
              exp_nxt     = in_expected_crc;
              rem_nxt     = hdr_len;
              cur_idx_nxt = '0;
              crc_nxt     = CRC_INIT;
              if (hdr_len == '0) begin
                // Empty block: verdict on the CRC of nothing.
                active_nxt      = 1'b0;
                pend_valid_nxt  = 1'b1;
                pend_nxt.kind   = KIND_VERD;
                pend_nxt.symbol = '0;
                pend_nxt.crc_ok = (in_expected_crc == '0);
                state_nxt       = S_FLUSH;
              end else begin
                active_nxt = 1'b1;
              end
            end
            MODE_DATA: begin
              if (active_r) begin
                byte_nxt   = in_data_byte;
                cnt_nxt    = '0;
                tbl_rd.en  = 1'b1;
                tbl_rd.idx = cur_idx_r;
                state_nxt  = S_RDCUR;
              end
            end
            default: begin
            end
          endcase
        end
      end

      S_RDCUR: begin
        cur_ent_nxt = rd_ent;
        state_nxt   = S_BIT;
      end

      S_BIT: begin
        if (cur_idx_r == '0 && cur_ent_r.leaf) begin
          // Root is a leaf: every bit yields its symbol.
          emit_req = 1'b1;
          emit_sym = cur_ent_r.symbol;
        end else begin
          child      = cur_bit ? cur_ent_r.right : cur_ent_r.left;
          tbl_rd.en  = 1'b1;
          tbl_rd.idx = child;
          child_nxt  = child;
          state_nxt  = S_CHILD;
        end
      end

      S_CHILD: begin
        if (rd_ent.leaf) begin
          emit_req = 1'b1;
          emit_sym = rd_ent.symbol;
        end else begin
          // Inner node: descend and, unless this was the last bit, fetch the next child right away.
          cur_idx_nxt = child_r;
          cur_ent_nxt = rd_ent;
          if (cnt_r == MSB_POS) begin
            state_nxt = S_FLUSH;
          end else begin
            cnt_nxt    = cnt_r + 3'd1;
            child      = next_bit ? rd_ent.right : rd_ent.left;
            tbl_rd.en  = 1'b1;
            tbl_rd.idx = child;
            child_nxt  = child;
          end
        end
      end

      S_VERD: begin
        if (out_free) begin
          out_valid_nxt   = 1'b1;
          out_nxt         = pend_r;
          out_last_nxt    = 1'b0;
          pend_valid_nxt  = 1'b1;
          pend_nxt.kind   = KIND_VERD;
          pend_nxt.symbol = '0;
          pend_nxt.crc_ok = (~crc_r == exp_r);
          state_nxt       = S_FLUSH;
        end
      end

      S_FLUSH: begin
        if (!pend_valid_r) begin
          state_nxt = S_IDLE;
        end else if (out_free) begin
          // The held beat is the final one of this item.
          out_valid_nxt  = 1'b1;
          out_nxt        = pend_r;
          out_last_nxt   = 1'b1;
          pend_valid_nxt = 1'b0;
          state_nxt      = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase

    // A new symbol pushes the held beat out (not last) and takes its place.
    // Hold the walk while the held beat cannot move.
    if (emit_req && (!pend_valid_r || out_free)) begin
      if (pend_valid_r) begin
        out_valid_nxt = 1'b1;
        out_nxt       = pend_r;
        out_last_nxt  = 1'b0;
      end
      pend_valid_nxt  = 1'b1;
      pend_nxt.kind   = KIND_SYM;
      pend_nxt.symbol = emit_sym;
      pend_nxt.crc_ok = 1'b0;
      crc_nxt         = crc32_byte(crc_r, emit_sym);
      rem_nxt         = rem_r - LENGTH_BITS'(1);
      cur_idx_nxt     = '0;
      cur_ent_nxt     = root_r;
      if (rem_r == LENGTH_BITS'(1)) begin
        active_nxt = 1'b0;
        state_nxt  = S_VERD;
      end else if (cnt_r == MSB_POS) begin
        state_nxt = S_FLUSH;
      end else begin
        cnt_nxt   = cnt_r + 3'd1;
        state_nxt = S_BIT;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      cur_idx_r    <= '0;
      crc_r        <= CRC_INIT;
      exp_r        <= '0;
      rem_r        <= '0;
      active_r     <= 1'b0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      cur_idx_r    <= cur_idx_nxt;
      crc_r        <= crc_nxt;
      exp_r        <= exp_nxt;
      rem_r        <= rem_nxt;
      active_r     <= active_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cnt_r      <= cnt_nxt;
    byte_r     <= byte_nxt;
    cur_ent_r  <= cur_ent_nxt;
    child_r    <= child_nxt;
    root_r     <= root_nxt;
    pend_r     <= pend_nxt;
    out_r      <= out_nxt;
    out_last_r <= out_last_nxt;
  end

endmodule

@@ hw/rtl/hbdcrc_node_tbl.sv @@
module hbdcrc_node_tbl #(
  parameter int NODE_COUNT = hbdcrc_pkg::NODE_COUNT_DEF
) (
  input  logic                 clk,
  input  hbdcrc_pkg::node_wr_t wr,
  input  hbdcrc_pkg::node_rd_t rd,
  output hbdcrc_pkg::node_t    rd_ent
);
  import hbdcrc_pkg::*;

  localparam int AW = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;

  node_t mem [NODE_COUNT];
  node_t rdata_r;
  logic  hit_r;

  logic wr_hit;
  logic rd_hit;

  assign wr_hit = 32'(wr.idx) < NODE_COUNT;
  assign rd_hit = 32'(rd.idx) < NODE_COUNT;

  always_ff @(posedge clk) begin
    if (wr.en && wr_hit) begin
      mem[AW'(wr.idx)] <= wr.entry;
    end
  end

  // Out-of-range reads return an all-zero entry.
  always_ff @(posedge clk) begin
    if (rd.en) begin
      rdata_r <= mem[AW'(rd.idx)];
      hit_r   <= rd_hit;
    end
  end

  assign rd_ent = hit_r ? rdata_r : '0;

endmodule

@@ hw/rtl/hbdcrc_checker.sv @@
module hbdcrc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_valid,
  input logic        in_ready,
  input logic [1:0]  in_mode,
  input logic [15:0] in_block_length,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_kind,
  input logic [7:0]  out_symbol,
  input logic        out_crc_ok,
  input logic        out_last
);
  import hbdcrc_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_symbol)
      && $stable(out_crc_ok) && $stable(out_last))
    else $error("stalled output beat changed");

  a_verd_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_VERD |-> out_last && out_symbol == '0)
    else $error("verdict beat not final or carries a symbol");

  a_sym_ok_clear: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == KIND_SYM |-> !out_crc_ok)
    else $error("symbol beat carries a crc verdict");

  a_empty_hdr_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && in_mode == MODE_HDR && in_block_length == '0 |=> !in_ready)
    else $error("empty block header did not hold input for its verdict");

endmodule

bind huffman_block_decoder_crc32_top hbdcrc_checker u_hbdcrc_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_valid),
  .in_ready       (in_ready),
  .in_mode        (in_mode),
  .in_block_length(in_block_length),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_kind       (out_kind),
  .out_symbol     (out_symbol),
  .out_crc_ok     (out_crc_ok),
  .out_last       (out_last)
);

@@ tb/sv/testbench.sv @@
`timescale 1ns / 1ps

module testbench;
  import hbdcrc_pkg::*;

  // Mode code that the block must ignore.
  localparam logic [1:0] MODE_SPARE = 2'd3;

  // Random input beats that do real work (ignored beats do not count).
  localparam int RANDOM_BEATS = 500;
  // Quiet cycles after the last expected beat, above the worst byte walk.
  localparam int DRAIN_CYCLES = 40;

  typedef struct {
    logic [1:0]  mode;
    logic [8:0]  idx;
    logic        leaf;
    logic [7:0]  sym;
    logic [8:0]  left;
    logic [8:0]  right;
    logic [31:0] crc;
    logic [15:0] len;
    logic [7:0]  data;
  } hbd_item_t;

  typedef struct {
    logic       kind;
    logic [7:0] sym;
    logic       ok;
    logic       last;
  } out_beat_t;

  // One row of the directed table. When typed is set, the expected output is
  // n beats of (kind, sym, ok) with last on the final one.
  typedef struct {
    hbd_item_t  it;
    bit         typed;
    int         n;
    logic       kind;
    logic [7:0] sym;
    logic       ok;
  } dir_row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;

  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [1:0]  in_mode = MODE_LOAD;
  logic [8:0]  in_node_index = '0;
  logic        in_node_is_leaf = 1'b0;
  logic [7:0]  in_node_symbol = '0;
  logic [8:0]  in_node_left = '0;
  logic [8:0]  in_node_right = '0;
  logic [31:0] in_expected_crc = '0;
  logic [15:0] in_block_length = '0;
  logic [7:0]  in_data_byte = '0;

  logic        out_valid;
  logic        out_ready = 1'b0;
  logic        out_kind;
  logic [7:0]  out_symbol;
  logic        out_crc_ok;
  logic        out_last;

  // Typed expectation that travels with the beat on the input port.
  logic        row_typed = 1'b0;
  int          row_n = 0;
  logic        row_kind = 1'b0;
  logic [7:0]  row_sym = '0;
  logic        row_ok = 1'b0;

  int send_idle = 0;
  int recv_idle = 0;

  huffman_block_decoder_crc32_top DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_node_index   (in_node_index),
    .in_node_is_leaf (in_node_is_leaf),
    .in_node_symbol  (in_node_symbol),
    .in_node_left    (in_node_left),
    .in_node_right   (in_node_right),
    .in_expected_crc (in_expected_crc),
    .in_block_length (in_block_length),
    .in_data_byte    (in_data_byte),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_kind        (out_kind),
    .out_symbol      (out_symbol),
    .out_crc_ok      (out_crc_ok),
    .out_last        (out_last)
  );

  always #5 clk = ~clk;

  // Watchdog: a hung handshake ends the run here.
  initial begin
    #20_000_000;
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------
  // Decoder shadow: node table, walk position, running CRC, block status.
  // ---------------------------------------------------------------------
  node_t       dec_table [0:511];
  logic [8:0]  dec_node = '0;
  logic [31:0] dec_crc = CRC_INIT;
  logic [15:0] dec_left = '0;
  logic [31:0] dec_exp_crc = '0;
  logic        dec_open = 1'b0;

  out_beat_t fresh_beats[$];      // beats caused by the beat just accepted
  out_beat_t expected_beats[$];   // beats still owed by the block

  int mismatches = 0;
  int beats_in = 0;
  int useful_in = 0;
  int beats_checked = 0;
  int verdicts_seen = 0;
  int verdicts_ok = 0;

  function automatic logic [31:0] crc_fold(input logic [31:0] c, input logic [7:0] b);
    logic [31:0] r;
    r = c ^ {24'h0, b};
    for (int k = 0; k < 8; k++) begin
      r = r[0] ? ((r >> 1) ^ CRC_POLY) : (r >> 1);
    end
    return r;
  endfunction

  function automatic void push_fresh(input logic kind, input logic [7:0] sym, input logic ok);
    out_beat_t b;
    b.kind = kind;
    b.sym  = sym;
    b.ok   = ok;
    b.last = 1'b0;
    fresh_beats.push_back(b);
  endfunction

  // Advance the shadow by one accepted beat and collect what it must emit.
  function automatic void decode_item(input hbd_item_t it);
    node_t      nd;
    node_t      ch;
    node_t      hit;
    logic [8:0] nxt;
    bit         emit;
    fresh_beats.delete();
    case (it.mode)
      MODE_LOAD: begin
        dec_table[it.idx] = {it.leaf, it.sym, it.left, it.right};
      end
      MODE_HDR: begin
        dec_exp_crc = it.crc;
        dec_left    = it.len;
        dec_node    = '0;
        dec_crc     = CRC_INIT;
        if (dec_left == 0) begin
          // Empty block: verdict on the CRC of no bytes, nothing stays open.
          dec_open = 1'b0;
          push_fresh(KIND_VERD, 8'h00, (~dec_crc) == dec_exp_crc);
        end else begin
          dec_open = 1'b1;
        end
      end
      MODE_DATA: begin
        for (int i = 0; i < 8 && dec_open; i++) begin
          nd   = dec_table[dec_node];
          emit = 1'b0;
          if (dec_node == 0 && nd.leaf) begin
            // Leaf at the root: every bit emits its symbol.
            hit  = nd;
            emit = 1'b1;
          end else begin
            nxt = it.data[MSB_POS - i] ? nd.right : nd.left;
            ch  = dec_table[nxt];
            if (ch.leaf) begin
              hit  = ch;
              emit = 1'b1;
            end else begin
              dec_node = nxt;
            end
          end
          if (emit) begin
            push_fresh(KIND_SYM, hit.symbol, 1'b0);
            dec_crc  = crc_fold(dec_crc, hit.symbol);
            dec_node = '0;
            dec_left = dec_left - 1'b1;
            if (dec_left == 0) begin
              // Length reached: drop the rest of the byte, report the verdict.
              dec_open = 1'b0;
              push_fresh(KIND_VERD, 8'h00, (~dec_crc) == dec_exp_crc);
            end
          end
        end
      end
      default: ;
    endcase
    if (fresh_beats.size() > 0) fresh_beats[fresh_beats.size() - 1].last = 1'b1;
  endfunction

  task automatic report_mismatch(input string what);
    $display("%0t mismatch: %s", $realtime, what);
    mismatches++;
  endtask

  // ---------------------------------------------------------------------
  // Scoreboard: one process sees both handshakes, input first, so that a
  // beat's expectations exist before any output of the same edge is checked.
  // ---------------------------------------------------------------------
  always @(posedge clk) begin : scoreboard
    hbd_item_t seen;
    out_beat_t want;
    bit        ignored;
    if (rst_n) begin
      if (in_valid && in_ready) begin
        seen.mode  = in_mode;
        seen.idx   = in_node_index;
        seen.leaf  = in_node_is_leaf;
        seen.sym   = in_node_symbol;
        seen.left  = in_node_left;
        seen.right = in_node_right;
        seen.crc   = in_expected_crc;
        seen.len   = in_block_length;
        seen.data  = in_data_byte;
        ignored = (seen.mode == MODE_SPARE) || (seen.mode == MODE_DATA && !dec_open);
        decode_item(seen);
        if (row_typed) begin
          // Replace the shadow's answer with the one written in the table.
          fresh_beats.delete();
          for (int k = 0; k < row_n; k++) begin
            want.kind = row_kind;
            want.sym  = row_sym;
            want.ok   = row_ok;
            want.last = (k == row_n - 1);
            fresh_beats.push_back(want);
          end
        end
        foreach (fresh_beats[k]) expected_beats.push_back(fresh_beats[k]);
        beats_in++;
        if (!ignored) useful_in++;
      end
      if (out_valid && out_ready) begin
        if (expected_beats.size() == 0) begin
          report_mismatch($sformatf("unexpected beat kind=%0d sym=%02h ok=%0d last=%0d",
                                    out_kind, out_symbol, out_crc_ok, out_last));
        end else begin
          want = expected_beats.pop_front();
          if (out_kind !== want.kind || out_symbol !== want.sym ||
              out_crc_ok !== want.ok || out_last !== want.last) begin
            report_mismatch($sformatf("got kind=%0d sym=%02h ok=%0d last=%0d, want %0d %02h %0d %0d",
                                      out_kind, out_symbol, out_crc_ok, out_last,
                                      want.kind, want.sym, want.ok, want.last));
          end
          beats_checked++;
          if (want.kind == KIND_VERD) begin
            verdicts_seen++;
            if (want.ok) verdicts_ok++;
          end
        end
      end
    end
  end

  // Receiver: stall on a share of cycles that the current phase sets.
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= recv_idle);
  end

  // ---------------------------------------------------------------------
  // Stimulus side: what has been loaded, and the code book of the current tree.
  // ---------------------------------------------------------------------
  bit          loaded[512];
  int          loaded_list[$];
  logic [7:0]  tree_sym[$];
  logic [31:0] tree_code[$];
  int          tree_len[$];
  bit          tree_root_leaf = 1'b0;
  bit          tree_dirty = 1'b1;

  dir_row_t dir_rows[$];

  function automatic hbd_item_t random_fields();
    hbd_item_t it;
    it.mode  = 2'($urandom());
    it.idx   = 9'($urandom());
    it.leaf  = 1'($urandom());
    it.sym   = 8'($urandom());
    it.left  = 9'($urandom());
    it.right = 9'($urandom());
    it.crc   = $urandom();
    it.len   = 16'($urandom());
    it.data  = 8'($urandom());
    return it;
  endfunction

  // Drive one beat; hold it until accepted. Idle first, on the phase's share.
  task automatic send_beat(input hbd_item_t it, input bit typed, input int n,
                           input logic kind, input logic [7:0] sym, input logic ok);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_mode         <= it.mode;
    in_node_index   <= it.idx;
    in_node_is_leaf <= it.leaf;
    in_node_symbol  <= it.sym;
    in_node_left    <= it.left;
    in_node_right   <= it.right;
    in_expected_crc <= it.crc;
    in_block_length <= it.len;
    in_data_byte    <= it.data;
    row_typed       <= typed;
    row_n           <= n;
    row_kind        <= kind;
    row_sym         <= sym;
    row_ok          <= ok;
    in_valid        <= 1'b1;
    if (it.mode == MODE_LOAD && !loaded[it.idx]) begin
      loaded[it.idx] = 1'b1;
      loaded_list.push_back(int'(it.idx));
    end
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send(input hbd_item_t it);
    send_beat(it, 1'b0, 0, 1'b0, 8'h00, 1'b0);
  endtask

  // Build a random full binary tree rooted at entry 0 with the given number of
  // leaves, load it root last, and keep its code book for block encoding.
  task automatic load_tree(input int leaves);
    int          s_idx[$];
    bit          s_leaf[$];
    int          s_left[$];
    int          s_right[$];
    logic [31:0] s_code[$];
    int          s_len[$];
    int          open_slots[$];
    bit          taken[512];
    int          p;
    int          s;
    int          a;
    hbd_item_t   it;
    s_idx.push_back(0);
    s_leaf.push_back(1'b1);
    s_left.push_back(0);
    s_right.push_back(0);
    s_code.push_back('0);
    s_len.push_back(0);
    open_slots.push_back(0);
    taken[0] = 1'b1;
    repeat (leaves - 1) begin
      p = $urandom_range(open_slots.size() - 1);
      s = open_slots[p];
      open_slots.delete(p);
      s_leaf[s] = 1'b0;
      for (int k = 0; k < 2; k++) begin
        do a = $urandom_range(511, 1); while (taken[a]);
        taken[a] = 1'b1;
        s_idx.push_back(a);
        s_leaf.push_back(1'b1);
        s_left.push_back(0);
        s_right.push_back(0);
        s_code.push_back((s_code[s] << 1) | 32'(k));
        s_len.push_back(s_len[s] + 1);
        open_slots.push_back(s_idx.size() - 1);
        if (k == 0) s_left[s] = a;
        else s_right[s] = a;
      end
    end
    tree_sym.delete();
    tree_code.delete();
    tree_len.delete();
    for (s = s_idx.size() - 1; s >= 0; s--) begin
      it      = random_fields();
      it.mode = MODE_LOAD;
      it.idx  = 9'(s_idx[s]);
      it.leaf = s_leaf[s];
      if (s_leaf[s]) begin
        // Point leaf children inside the tree so a later rewrite stays safe.
        it.left  = 9'(s_idx[$urandom_range(s_idx.size() - 1)]);
        it.right = 9'(s_idx[$urandom_range(s_idx.size() - 1)]);
        tree_sym.push_back(it.sym);
        tree_code.push_back(s_code[s]);
        tree_len.push_back(s_len[s]);
      end else begin
        it.left  = 9'(s_left[s]);
        it.right = 9'(s_right[s]);
      end
      send(it);
    end
    tree_root_leaf = (leaves == 1);
    tree_dirty = 1'b0;
  endtask

  // Any beat that is not part of a well-formed block. Loads only point at
  // entries already written, so no walk ever reads an empty entry.
  task automatic send_noise();
    hbd_item_t it;
    it = random_fields();
    case ($urandom_range(3))
      0: it.mode = MODE_SPARE;
      1: it.mode = MODE_DATA;
      2: begin
        it.mode  = MODE_LOAD;
        it.left  = 9'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        it.right = 9'(loaded_list[$urandom_range(loaded_list.size() - 1)]);
        tree_dirty = 1'b1;
      end
      default: begin
        it.mode = MODE_HDR;
        if ($urandom_range(3) != 0) it.len = 16'($urandom_range(6, 1));
      end
    endcase
    send(it);
  endtask

  // Encode a random message with the current code book and send it as one
  // block: header, then the packed bytes. Optionally corrupt the CRC, cut the
  // block short, or slip noise between data bytes.
  task automatic send_block(input int nsym, input bit good, input bit cut, input bit noisy);
    bit          bits[$];
    logic [31:0] c;
    logic [7:0]  by;
    int          li;
    int          stop;
    hbd_item_t   it;
    c = CRC_INIT;
    for (int j = 0; j < nsym; j++) begin
      li = $urandom_range(tree_sym.size() - 1);
      c  = crc_fold(c, tree_sym[li]);
      if (tree_root_leaf) begin
        bits.push_back(1'($urandom_range(1)));
      end else begin
        for (int b = tree_len[li] - 1; b >= 0; b--) bits.push_back(tree_code[li][b]);
      end
    end
    // Pad the final byte; the block must ignore these bits.
    while (bits.size() % 8 != 0) bits.push_back(1'($urandom_range(1)));
    it      = random_fields();
    it.mode = MODE_HDR;
    it.crc  = good ? ~c : (~c) ^ (32'h1 << $urandom_range(31));
    it.len  = 16'(nsym);
    send(it);
    stop = cut ? $urandom_range(bits.size() / 8) : bits.size() / 8;
    for (int j = 0; j < stop; j++) begin
      for (int b = 0; b < 8; b++) by[7 - b] = bits[8 * j + b];
      if (noisy && $urandom_range(4) == 0) send_noise();
      it      = random_fields();
      it.mode = MODE_DATA;
      it.data = by;
      send(it);
    end
  endtask

  function automatic dir_row_t row(input logic [1:0] mode, input logic [8:0] idx,
                                   input logic leaf, input logic [7:0] sym,
                                   input logic [8:0] left, input logic [8:0] right,
                                   input logic [31:0] crc, input logic [15:0] len,
                                   input logic [7:0] data);
    dir_row_t r;
    r.it.mode  = mode;
    r.it.idx   = idx;
    r.it.leaf  = leaf;
    r.it.sym   = sym;
    r.it.left  = left;
    r.it.right = right;
    r.it.crc   = crc;
    r.it.len   = len;
    r.it.data  = data;
    r.typed = 1'b0;
    r.n     = 0;
    r.kind  = 1'b0;
    r.sym   = '0;
    r.ok    = 1'b0;
    return r;
  endfunction

  function automatic dir_row_t typed(input dir_row_t r, input int n, input logic kind,
                                     input logic [7:0] sym, input logic ok);
    r.typed = 1'b1;
    r.n     = n;
    r.kind  = kind;
    r.sym   = sym;
    r.ok    = ok;
    return r;
  endfunction

  initial begin
    int random_base;
    int episode;
    int leaves;

    // Directed table. Trees here: first a lone leaf at the root, then
    // 0 -> {511 leaf FF, 1 -> {2 leaf 00, 3 leaf 7F}}.
    // Empty blocks straight after reset: CRC of no bytes is zero.
    dir_rows.push_back(typed(row(MODE_HDR, 0, 0, 0, 0, 0, 32'h0000_0000, 16'd0, 8'h00),
                             1, KIND_VERD, 8'h00, 1'b1));
    dir_rows.push_back(typed(row(MODE_HDR, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'd0, 8'h00),
                             1, KIND_VERD, 8'h00, 1'b0));
    // Data with no open block, and the spare mode with every bit set.
    dir_rows.push_back(typed(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'hFF),
                             0, KIND_SYM, 8'h00, 1'b0));
    dir_rows.push_back(typed(row(MODE_SPARE, 9'h1FF, 1, 8'hFF, 9'h1FF, 9'h1FF,
                                 32'hFFFF_FFFF, 16'hFFFF, 8'hFF), 0, KIND_SYM, 8'h00, 1'b0));
    // Leaf at the root: each bit emits its symbol.
    dir_rows.push_back(typed(row(MODE_LOAD, 0, 1, 8'hA5, 0, 0, 32'h0, 16'd0, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));
    dir_rows.push_back(typed(row(MODE_HDR, 0, 0, 0, 0, 0, 32'h1234_5678, 16'd20, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));
    dir_rows.push_back(typed(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h00),
                             8, KIND_SYM, 8'hA5, 1'b0));
    dir_rows.push_back(typed(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'hFF),
                             8, KIND_SYM, 8'hA5, 1'b0));
    // Length runs out inside this byte: rest of the bits dropped.
    dir_rows.push_back(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h5A));
    // Three-leaf tree, top entry used as a leaf.
    dir_rows.push_back(row(MODE_LOAD, 9'h1FF, 1, 8'hFF, 9'h1FF, 9'h1FF, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(row(MODE_LOAD, 2, 1, 8'h00, 0, 0, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(row(MODE_LOAD, 3, 1, 8'h7F, 0, 0, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(row(MODE_LOAD, 1, 0, 8'h00, 2, 3, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(row(MODE_LOAD, 0, 0, 8'h00, 9'h1FF, 1, 32'h0, 16'd0, 8'h00));
    // Longest block, never finished.
    dir_rows.push_back(typed(row(MODE_HDR, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 16'hFFFF, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));
    dir_rows.push_back(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h5B));
    dir_rows.push_back(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'hF0));
    // Node rewrite inside a block takes effect at once.
    dir_rows.push_back(row(MODE_LOAD, 1, 1, 8'h3C, 2, 3, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'hC3));
    dir_rows.push_back(typed(row(MODE_SPARE, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));
    // Header inside a block abandons it without a verdict.
    dir_rows.push_back(typed(row(MODE_HDR, 0, 0, 0, 0, 0, 32'hCBF4_3926, 16'd2, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));
    dir_rows.push_back(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h00));
    dir_rows.push_back(typed(row(MODE_DATA, 0, 0, 0, 0, 0, 32'h0, 16'd0, 8'h00),
                             0, KIND_SYM, 8'h00, 1'b0));

    // Hold reset, then release on a rising edge.
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Phase one: sender idles a little, receiver stalls a lot.
    send_idle = 10;
    recv_idle <= 74;
    foreach (dir_rows[r]) begin
      send_beat(dir_rows[r].it, dir_rows[r].typed, dir_rows[r].n,
                dir_rows[r].kind, dir_rows[r].sym, dir_rows[r].ok);
    end

    // Random part: mostly well-formed blocks on fresh trees, some noise.
    random_base = useful_in;
    episode = 0;
    while (useful_in - random_base < RANDOM_BEATS) begin
      if (useful_in - random_base >= 2 * RANDOM_BEATS / 3) begin
        send_idle = 0;
        recv_idle <= 0;
      end else if (useful_in - random_base >= RANDOM_BEATS / 3) begin
        send_idle = 74;
        recv_idle <= 10;
      end
      episode = $urandom_range(99);
      if (tree_dirty || episode < 12) begin
        leaves = ($urandom_range(4) == 0) ? 1 : $urandom_range(12, 2);
        load_tree(leaves);
      end else if (episode < 80) begin
        send_block(($urandom_range(9) == 0) ? 0 : $urandom_range(10, 1),
                   $urandom_range(3) != 0, $urandom_range(9) == 0, $urandom_range(9) == 0);
      end else begin
        repeat ($urandom_range(3, 1)) send_noise();
      end
    end
    in_valid <= 1'b0;

    // Let the scoreboard take the last beat, drain, then sit out the latency.
    @(posedge clk);
    while (expected_beats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d input beats (%0d doing work), %0d output beats checked",
             beats_in, useful_in, beats_checked);
    $display("block verdicts checked: %0d, of which %0d with matching CRC",
             verdicts_seen, verdicts_ok);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
hw/rtl/hbdcrc_pkg.sv
hw/rtl/hbdcrc_node_tbl.sv
hw/rtl/huffman_block_decoder_crc32_top.sv
hw/rtl/hbdcrc_checker.sv
tb/sv/testbench.sv
